FILE: sv/voxel_grid_downsampler_top_defines.svh
// Assertion macros for the voxel grid downsampler checker.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef VOXEL_GRID_DOWNSAMPLER_TOP_DEFINES_SVH
`define VOXEL_GRID_DOWNSAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define VGD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define VGD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/vgd_pkg.sv
// Shared constants for the voxel grid downsampler: opcodes, status codes, widths.
// No dependencies.
package vgd_pkg;

  localparam int VOXEL_CELLS_DEF = 4096;
  localparam int COORD_BITS_DEF  = 32;

  localparam int CELL_W = 31;
  localparam int OP_W   = 2;
  localparam int ST_W   = 3;

  localparam logic [CELL_W-1:0] CELL_RESET = 31'd65536;  // 1.0 in Q16.16

  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_BOUND = 2'd1;
  localparam logic [OP_W-1:0] OP_BIN   = 2'd2;
  localparam logic [OP_W-1:0] OP_EMIT  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK   = 3'd0;
  localparam logic [ST_W-1:0] ST_DROP = 3'd1;
  localparam logic [ST_W-1:0] ST_BIG  = 3'd2;
  localparam logic [ST_W-1:0] ST_ZERO = 3'd3;
  localparam logic [ST_W-1:0] ST_DONE = 3'd4;

endpackage

FILE: sv/voxel_grid_downsampler_top.sv
// Voxel grid downsampler: bound, bin and emit passes over a Q16.16 point cloud,
// built from a sequencer around vgd_div and one shared multiplier; uses vgd_pkg.
//
// One item is taken at a time; in_tready is high only while the sequencer is idle,
// and a finished result may wait in the output register while the next item is
// taken. A start sweeps the occupancy memory. A bin or emit item first rebuilds the
// grid if the bounds or the cell size changed since the last rebuild: six divisions
// plus two multiplies. A bin point then takes three divisions and the index
// multiplies. An emit walks the occupancy memory from the scan pointer, reading and
// checking each entry in turn, then two divisions split the voxel index and three
// multiplies form the corner after the hit. The serial divider sets the pace of the
// grid rebuild, the bin and the index split; the scan and the clear sweep run
// without it. A zero cell size answers a bin or emit at once with status 3. After
// reset the block sweeps the occupancy memory clear before it takes its first item;
// cell size writes are taken throughout.
module voxel_grid_downsampler_top #(
  parameter int VOXEL_CELLS = vgd_pkg::VOXEL_CELLS_DEF,
  parameter int COORD_BITS  = vgd_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: px, py, pz (low bits up), zero padded to bytes
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  // in_tuser: opcode
  input  logic [vgd_pkg::OP_W-1:0]             in_tuser,
  // out_tdata: vx, vy, vz (low bits up), zero padded to bytes
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((3*COORD_BITS+7)/8)*8-1:0]    out_tdata,
  // out_tuser: status
  output logic [vgd_pkg::ST_W-1:0]             out_tuser,
  input  logic                                 cfg_wr_en,
  input  logic [vgd_pkg::CELL_W-1:0]           cfg_wr_data
);

  localparam int CB   = COORD_BITS;
  localparam int CW   = vgd_pkg::CELL_W;
  localparam int AW   = $clog2(VOXEL_CELLS);
  localparam int DIMW = $clog2(VOXEL_CELLS + 1);
  localparam int DW   = ((CB + 1) > (DIMW + 1)) ? (CB + 1) : (DIMW + 1);
  localparam int RW   = DW + 2;
  localparam int PW   = DIMW + CW;
  localparam int SUMW = ((PW > CB) ? PW : CB) + 2;
  localparam int TDW  = ((3*CB+7)/8)*8;

  localparam logic signed [RW-1:0]   CELLS_R = RW'(VOXEL_CELLS);
  localparam logic [PW-1:0]          CELLS_P = PW'(VOXEL_CELLS);
  localparam logic [AW-1:0]          CLR_END = AW'(VOXEL_CELLS - 1);
  localparam logic signed [SUMW-1:0] VMAX = {{(SUMW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [SUMW-1:0] VMIN = {{(SUMW-CB+1){1'b1}}, {(CB-1){1'b0}}};

  typedef enum logic [16:0] {
    S_CLEAR = 17'h00001,
    S_IDLE  = 17'h00002,
    S_GDIV  = 17'h00004,
    S_GM1   = 17'h00008,
    S_GM2   = 17'h00010,
    S_GM3   = 17'h00020,
    S_DISP  = 17'h00040,
    S_BDIV  = 17'h00080,
    S_BI1   = 17'h00100,
    S_BI2   = 17'h00200,
    S_BI3   = 17'h00400,
    S_SRD   = 17'h00800,
    S_SCHK  = 17'h01000,
    S_EDIV  = 17'h02000,
    S_EMM   = 17'h04000,
    S_EMA   = 17'h08000,
    S_OUT   = 17'h10000
  } state_t;

  state_t state_r;

  logic [vgd_pkg::OP_W-1:0] op_r;
  logic signed [CB-1:0]     p_r    [3];
  logic signed [CB-1:0]     low_r  [3];
  logic signed [CB-1:0]     high_r [3];
  logic                     seen_r;
  logic [CW-1:0]            cell_r;
  logic                     grid_ok_r;
  logic                     grid_big_r;
  logic [DIMW-1:0]          dim_r  [3];
  logic [DIMW-1:0]          cells_r;
  logic [DIMW-1:0]          scan_r;
  logic [DIMW-1:0]          ei_r;
  logic [DIMW-1:0]          tq_r;
  logic [DIMW-1:0]          pos_r  [3];
  logic [DIMW-1:0]          g_r    [3];
  logic [2:0]               k_r;
  logic signed [RW-1:0]     racc_r;
  logic [AW-1:0]            clr_addr_r;
  logic                     clr_reply_r;
  logic                     div_run_r;
  logic [PW-1:0]            mul_p_r;
  logic                     occ_q_r;
  logic [vgd_pkg::ST_W-1:0] res_st_r;
  logic signed [CB-1:0]     res_v_r [3];
  logic                     out_valid_r;
  logic [vgd_pkg::ST_W-1:0] out_st_r;
  logic [CB-1:0]            out_v_r [3];

  logic occ_mem [VOXEL_CELLS];

  // divider hookup
  logic                 div_start;
  logic signed [DW-1:0] div_dividend;
  logic [CW-1:0]        div_divisor;
  logic                 div_done;
  logic signed [DW-1:0] div_quot;
  logic [CW-1:0]        div_rem;

  vgd_div #(.DW(DW), .VW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  logic [1:0]           ax;
  logic [1:0]           kk;
  logic signed [RW-1:0] q_ext;
  logic signed [RW-1:0] racc_lo;
  logic signed [RW-1:0] r_hi;
  logic                 axis_big;
  logic [DIMW-1:0]      dim_new;
  logic signed [DW-1:0] dim_ext;
  logic                 bin_drop;
  logic signed [SUMW-1:0] sum;
  logic signed [CB-1:0] vsat;
  logic [DIMW-1:0]      mul_a;
  logic [CW-1:0]        mul_b;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [DIMW-1:0]      bin_idx;
  logic signed [CB-1:0] in_p [3];
  logic                 grid_stale;
  logic                 out_load;

  assign in_p[0] = $signed(in_tdata[CB-1:0]);
  assign in_p[1] = $signed(in_tdata[2*CB-1:CB]);
  assign in_p[2] = $signed(in_tdata[3*CB-1:2*CB]);

  assign ax = k_r[2:1];
  assign kk = k_r[1:0];

  // a start or a bound point taken now invalidates the cached grid
  assign grid_stale = in_tready && in_tvalid &&
                      ((in_tuser == vgd_pkg::OP_START) || (in_tuser == vgd_pkg::OP_BOUND));
  // result moves into the output register
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    // grid edge: r = trunc(M/c) + (M>0) - trunc(m/c) + (m<0)
    q_ext    = {{(RW-DW){div_quot[DW-1]}}, div_quot};
    racc_lo  = -q_ext + RW'(low_r[ax][CB-1]);
    r_hi     = racc_r + q_ext
             + RW'(!high_r[ax][CB-1] && (high_r[ax] != '0));
    axis_big = (r_hi >= CELLS_R);
    dim_new  = r_hi[RW-1] ? DIMW'(1) : (r_hi[DIMW-1:0] + DIMW'(1));

    dim_ext  = {{(DW-DIMW){1'b0}}, dim_r[kk]};
    bin_drop = div_quot[DW-1] || (div_quot >= dim_ext);

    sum = {{(SUMW-CB){low_r[kk][CB-1]}}, low_r[kk]} + {{(SUMW-PW){1'b0}}, mul_p_r};
    if (sum > VMAX) begin
      vsat = VMAX[CB-1:0];
    end else if (sum < VMIN) begin
      vsat = VMIN[CB-1:0];
    end else begin
      vsat = sum[CB-1:0];
    end

    bin_idx = mul_p_r[DIMW-1:0] + pos_r[2];
  end

  // divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = cell_r;
    case (state_r)
      S_GDIV: begin
        div_start    = !div_run_r;
        div_dividend = k_r[0] ? {{(DW-CB){high_r[ax][CB-1]}}, high_r[ax]}
                              : {{(DW-CB){low_r[ax][CB-1]}}, low_r[ax]};
      end
      S_BDIV: begin
        div_start    = !div_run_r;
        div_dividend = {{(DW-CB){p_r[kk][CB-1]}}, p_r[kk]}
                     - {{(DW-CB){low_r[kk][CB-1]}}, low_r[kk]};
      end
      S_EDIV: begin
        div_start    = !div_run_r;
        div_dividend = k_r[0] ? {{(DW-DIMW){1'b0}}, tq_r} : {{(DW-DIMW){1'b0}}, ei_r};
        div_divisor  = k_r[0] ? CW'(dim_r[1]) : CW'(dim_r[2]);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_GM1: begin
        mul_a = dim_r[0];
        mul_b = CW'(dim_r[1]);
      end
      S_GM2: begin
        mul_a = mul_p_r[DIMW-1:0];
        mul_b = CW'(dim_r[2]);
      end
      S_BI1: begin
        mul_a = pos_r[0];
        mul_b = CW'(dim_r[1]);
      end
      S_BI2: begin
        mul_a = mul_p_r[DIMW-1:0] + pos_r[1];
        mul_b = CW'(dim_r[2]);
      end
      S_EMM: begin
        mul_a = g_r[kk];
        mul_b = cell_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= PW'(mul_a) * PW'(mul_b);
  end

  // occupancy memory: one write port (clear sweep or bin mark), one registered read
  assign mem_we = (state_r == S_CLEAR) || (state_r == S_BI3);
  assign mem_wa = (state_r == S_CLEAR) ? clr_addr_r : bin_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_wa] <= (state_r == S_BI3);
    end
    occ_q_r <= occ_mem[scan_r[AW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cell_r      <= vgd_pkg::CELL_RESET;
      for (int a = 0; a < 3; a++) begin
        low_r[a]  <= '0;
        high_r[a] <= '0;
      end
      seen_r      <= 1'b0;
      grid_ok_r   <= 1'b0;
      grid_big_r  <= 1'b0;
      scan_r      <= '0;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      div_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (div_start) begin
        div_run_r <= 1'b1;
      end else if (div_done) begin
        div_run_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == CLR_END) begin
            state_r <= clr_reply_r ? S_OUT : S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_tvalid) begin
            op_r <= in_tuser;
            for (int a = 0; a < 3; a++) begin
              p_r[a]     <= in_p[a];
              res_v_r[a] <= '0;
            end
            case (in_tuser)
              vgd_pkg::OP_START: begin
                for (int a = 0; a < 3; a++) begin
                  low_r[a]  <= '0;
                  high_r[a] <= '0;
                end
                res_st_r    <= vgd_pkg::ST_OK;
                seen_r      <= 1'b0;
                scan_r      <= '0;
                clr_addr_r  <= '0;
                clr_reply_r <= 1'b1;
                state_r     <= S_CLEAR;
              end
              vgd_pkg::OP_BOUND: begin
                for (int a = 0; a < 3; a++) begin
                  if (!seen_r || (in_p[a] < low_r[a])) low_r[a] <= in_p[a];
                  if (!seen_r || (in_p[a] > high_r[a])) high_r[a] <= in_p[a];
                end
                res_st_r <= vgd_pkg::ST_OK;
                seen_r   <= 1'b1;
                state_r  <= S_OUT;
              end
              default: begin
                res_st_r <= (cell_r == '0) ? vgd_pkg::ST_ZERO : vgd_pkg::ST_OK;
                if (cell_r == '0) begin
                  state_r <= S_OUT;
                end else if (grid_ok_r) begin
                  state_r <= S_DISP;
                end else begin
                  k_r        <= '0;
                  grid_big_r <= 1'b0;
                  state_r    <= S_GDIV;
                end
              end
            endcase
          end
        end

        // six divisions: low then high corner per axis
        S_GDIV: begin
          if (div_done) begin
            if (!k_r[0]) begin
              racc_r <= racc_lo;
              k_r    <= k_r + 3'd1;
            end else begin
              dim_r[ax] <= dim_new;
              if (axis_big) grid_big_r <= 1'b1;
              if (k_r == 3'd5) begin
                k_r <= '0;
                if (axis_big || grid_big_r) begin
                  if (!cfg_wr_en) grid_ok_r <= 1'b1;
                  state_r <= S_DISP;
                end else begin
                  state_r <= S_GM1;
                end
              end else begin
                k_r <= k_r + 3'd1;
              end
            end
          end
        end

        S_GM1: state_r <= S_GM2;

        S_GM2: begin
          if (mul_p_r > CELLS_P) begin
            grid_big_r <= 1'b1;
            if (!cfg_wr_en) grid_ok_r <= 1'b1;
            state_r    <= S_DISP;
          end else begin
            state_r <= S_GM3;
          end
        end

        S_GM3: begin
          if (mul_p_r > CELLS_P) begin
            grid_big_r <= 1'b1;
          end else begin
            cells_r <= mul_p_r[DIMW-1:0];
          end
          if (!cfg_wr_en) grid_ok_r <= 1'b1;
          state_r <= S_DISP;
        end

        S_DISP: begin
          k_r <= '0;
          if (grid_big_r) begin
            res_st_r <= vgd_pkg::ST_BIG;
            state_r  <= S_OUT;
          end else if (op_r == vgd_pkg::OP_BIN) begin
            state_r <= S_BDIV;
          end else begin
            state_r <= S_SRD;
          end
        end

        S_BDIV: begin
          if (div_done) begin
            if (bin_drop) begin
              res_st_r <= vgd_pkg::ST_DROP;
              state_r  <= S_OUT;
            end else begin
              pos_r[kk] <= div_quot[DIMW-1:0];
              if (kk == 2'd2) begin
                state_r <= S_BI1;
              end else begin
                k_r <= k_r + 3'd1;
              end
            end
          end
        end

        S_BI1: state_r <= S_BI2;
        S_BI2: state_r <= S_BI3;
        S_BI3: state_r <= S_OUT;

        S_SRD: begin
          if (scan_r >= cells_r) begin
            scan_r   <= cells_r;
            res_st_r <= vgd_pkg::ST_DONE;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_SCHK;
          end
        end

        S_SCHK: begin
          scan_r <= scan_r + DIMW'(1);
          if (occ_q_r) begin
            ei_r    <= scan_r;
            k_r     <= '0;
            state_r <= S_EDIV;
          end else begin
            state_r <= S_SRD;
          end
        end

        // i / dz -> (t, gz); t / dy -> (gx, gy)
        S_EDIV: begin
          if (div_done) begin
            if (!k_r[0]) begin
              g_r[2] <= div_rem[DIMW-1:0];
              tq_r   <= div_quot[DIMW-1:0];
              k_r    <= 3'd1;
            end else begin
              g_r[0]  <= div_quot[DIMW-1:0];
              g_r[1]  <= div_rem[DIMW-1:0];
              k_r     <= '0;
              state_r <= S_EMM;
            end
          end
        end

        S_EMM: state_r <= S_EMA;

        S_EMA: begin
          res_v_r[kk] <= vsat;
          if (kk == 2'd2) begin
            state_r <= S_OUT;
          end else begin
            k_r     <= k_r + 3'd1;
            state_r <= S_EMM;
          end
        end

        S_OUT: begin
          if (out_load) begin
            out_st_r <= res_st_r;
            for (int a = 0; a < 3; a++) begin
              out_v_r[a] <= res_v_r[a];
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase

      if (cfg_wr_en) begin
        cell_r <= cfg_wr_data;
      end
      if (cfg_wr_en || grid_stale) begin
        grid_ok_r <= 1'b0;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = TDW'({out_v_r[2], out_v_r[1], out_v_r[0]});

endmodule

FILE: sv/vgd_div.sv
// Shared restoring divider, one quotient bit per cycle, truncating signed quotient.
// Depends on nothing; instantiated by voxel_grid_downsampler_top.
module vgd_div #(
  parameter int DW = 33,
  parameter int VW = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic [VW-1:0]        divisor,
  output logic                 done,
  output logic signed [DW-1:0] quot,
  output logic [VW-1:0]        rem
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VW-1:0]    acc_r;
  logic [DW-1:0]    q_r;
  logic [VW-1:0]    dsr_r;
  logic             neg_r;
  logic [VW:0]      sh;
  logic [VW:0]      diff;

  assign sh   = {acc_r, q_r[DW-1]};
  assign diff = sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
        acc_r  <= '0;
        q_r    <= dividend[DW-1] ? -dividend : dividend;
        neg_r  <= dividend[DW-1];
        dsr_r  <= divisor;
      end else if (busy_r) begin
        if (!diff[VW]) begin
          acc_r <= diff[VW-1:0];
          q_r   <= {q_r[DW-2:0], 1'b1};
        end else begin
          acc_r <= sh[VW-1:0];
          q_r   <= {q_r[DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);
  assign rem  = acc_r;

endmodule

FILE: sv/vgd_chk.sv
// Port-level checker for voxel_grid_downsampler_top, attached by bind below.
// Depends on vgd_pkg and voxel_grid_downsampler_top_defines.svh.
`include "voxel_grid_downsampler_top_defines.svh"

module vgd_chk #(
  parameter int COORD_BITS = vgd_pkg::COORD_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((3*COORD_BITS+7)/8)*8-1:0] out_tdata,
  input logic [vgd_pkg::ST_W-1:0]          out_tuser
);

  // one item at a time: the sequencer leaves idle on every input transfer
  `VGD_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready, "ready after transfer")

  // reset starts the occupancy clear sweep
  `VGD_ASSERT_SAME(a_clear_after_rst, !$past(rst_n), !in_tready, "ready during clear sweep")

  // only a successful emit carries a corner
  `VGD_ASSERT_SAME(a_zero_corner, out_tvalid && (out_tuser != vgd_pkg::ST_OK), out_tdata == '0, "corner on non-ok result")

  `VGD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind voxel_grid_downsampler_top vgd_chk #(.COORD_BITS(COORD_BITS)) u_vgd_chk (.*);
